@@ hw/rtl/odk_pkg.sv @@
// ----------------------------------------------------------------------------
// odk_pkg
// Shared widths, constants and types of the omni drive kinematics pipeline.
// ----------------------------------------------------------------------------
package odk_pkg;

  localparam int COEFF_FRAC_BITS = 16;

  localparam int STEPS_W  = 12;
  localparam int MINSPD_W = 18;
  localparam int ACC_W    = 16;
  localparam int DIN_W    = 16;
  localparam int SPDIN_W  = 13;
  localparam int CFG_W    = 18;
  localparam int IDX_W    = 2;

  localparam int DXS_W  = 28;            // scaled delta, signed
  localparam int ABS_W  = DXS_W - 1;
  localparam int DIST_W = 28;
  localparam int SQ_W   = 2 * DIST_W;
  localparam int REM_W  = DIST_W + 3;
  localparam int SPD_W  = SPDIN_W + STEPS_W;
  localparam int T_W    = 45;            // wheel travel in Q.16, signed
  localparam int MAG_W  = T_W - 1;
  localparam int KP_W   = T_W + 1;

  localparam int CA     = (COEFF_FRAC_BITS >= 16) ? COEFF_FRAC_BITS - 16 : 0;
  localparam int CB     = (COEFF_FRAC_BITS >= 16) ? 0 : 16 - COEFF_FRAC_BITS;
  localparam int QW     = COEFF_FRAC_BITS + 2;
  localparam int NUM_W  = MAG_W + CA;
  localparam int DEN_W  = DIST_W + CB;

  localparam int TGT_W  = 32;
  localparam int CRU_W  = 26;
  localparam int STA_W  = 19;
  localparam int ACCO_W = 17;

  localparam logic [16:0] K0866_Q16 = 17'd56754;

  // accept -> result strobe, in cycles
  localparam int LAT = 3 + DIST_W + 1 + QW + 2;

  typedef enum logic [IDX_W-1:0] {
    REG_STEPS_PER_MM = 2'd0,
    REG_MIN_SPEED    = 2'd1,
    REG_MAX_ACCEL    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0][T_W-1:0] t16;
    logic [SPD_W-1:0]    spd;
  } side_t;

  function automatic logic [63:0] sat_u(input logic [63:0] v, input int w);
    logic [63:0] vmax;
    vmax = (64'd1 << w) - 64'd1;
    return (v > vmax) ? vmax : v;
  endfunction

endpackage

@@ hw/rtl/odk_front.sv @@
// ----------------------------------------------------------------------------
// odk_front
// Scales the request to microsteps, squares the deltas and forms wheel travel.
// ----------------------------------------------------------------------------
module odk_front
  import odk_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic signed [DIN_W-1:0]    in_dx,
  input  logic signed [DIN_W-1:0]    in_dy,
  input  logic [SPDIN_W-1:0]         in_spd,
  input  logic [STEPS_W-1:0]         steps,
  output logic                       out_valid,
  output logic [SQ_W-1:0]            out_sq,
  output side_t                      out_side
);

  logic                     v1_r, v2_r, v3_r;
  logic signed [DXS_W-1:0]  dx1_r, dy1_r, dx2_r;
  logic [SPD_W-1:0]         spd1_r, spd2_r;
  logic [2*ABS_W-1:0]       sqx_r, sqy_r;
  logic signed [T_W-1:0]    kdy_r;
  logic [SQ_W-1:0]          sq_r;
  side_t                    side_r;

  logic signed [DIN_W+STEPS_W:0] dxp, dyp;
  logic signed [DXS_W-1:0]       dxn, dyn;
  logic [ABS_W-1:0]              ax, ay;
  logic signed [KP_W-1:0]        kp;
  logic signed [T_W-1:0]         dxe, t0, t1, t2;

  assign dxp = in_dx * $signed({1'b0, steps});
  assign dyp = in_dy * $signed({1'b0, steps});
  assign dxn = -dx1_r;
  assign dyn = -dy1_r;
  assign ax  = dx1_r[DXS_W-1] ? dxn[ABS_W-1:0] : dx1_r[ABS_W-1:0];
  assign ay  = dy1_r[DXS_W-1] ? dyn[ABS_W-1:0] : dy1_r[ABS_W-1:0];
  assign kp  = $signed({1'b0, K0866_Q16}) * dy1_r;

  assign dxe = {{(T_W-DXS_W){dx2_r[DXS_W-1]}}, dx2_r};
  assign t0  = -(dxe <<< 16);
  assign t1  = (dxe <<< 15) - kdy_r;
  assign t2  = (dxe <<< 15) + kdy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r  <= dxp[DXS_W-1:0];
    dy1_r  <= dyp[DXS_W-1:0];
    spd1_r <= in_spd * steps;
    sqx_r  <= ax * ax;
    sqy_r  <= ay * ay;
    kdy_r  <= kp[T_W-1:0];
    dx2_r  <= dx1_r;
    spd2_r <= spd1_r;
    sq_r   <= SQ_W'(sqx_r) + SQ_W'(sqy_r);
    side_r.t16[0] <= t0;
    side_r.t16[1] <= t1;
    side_r.t16[2] <= t2;
    side_r.spd    <= spd2_r;
  end

  assign out_valid = v3_r;
  assign out_sq    = sq_r;
  assign out_side  = side_r;

endmodule

@@ hw/rtl/odk_isqrt.sv @@
// ----------------------------------------------------------------------------
// odk_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module odk_isqrt
  import odk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [SQ_W-1:0]    in_x,
  input  side_t              in_side,
  output logic               out_valid,
  output logic [DIST_W-1:0]  out_root,
  output side_t              out_side
);

  logic                vld_r  [DIST_W];
  logic [REM_W-1:0]    rem_r  [DIST_W];
  logic [DIST_W-1:0]   root_r [DIST_W];
  logic [SQ_W-1:0]     x_r    [DIST_W];
  side_t               side_r [DIST_W];

  for (genvar k = 0; k < DIST_W; k++) begin : g_stage
    logic              vld_p;
    logic [REM_W-1:0]  rem_p, remn, trial, rem_nxt;
    logic [DIST_W-1:0] root_p, root_nxt;
    logic [SQ_W-1:0]   x_p;
    side_t             side_p;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = in_x;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign x_p    = x_r[k-1];
      assign side_p = side_r[k-1];
    end

    assign remn     = {rem_p[REM_W-3:0], x_p[SQ_W-1:SQ_W-2]};
    assign trial    = {{(REM_W-DIST_W-2){1'b0}}, root_p, 2'b01};
    assign ge       = (remn >= trial);
    assign rem_nxt  = ge ? (remn - trial) : remn;
    assign root_nxt = {root_p[DIST_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      x_r[k]    <= {x_p[SQ_W-3:0], 2'b00};
      side_r[k] <= side_p;
    end
  end

  assign out_valid = vld_r[DIST_W-1];
  assign out_root  = root_r[DIST_W-1];
  assign out_side  = side_r[DIST_W-1];

  a_sqrt_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, DIST_W))
    else $error("isqrt result without a request");

endmodule

@@ hw/rtl/odk_div3.sv @@
// ----------------------------------------------------------------------------
// odk_div3
// Three-lane pipelined divider: per-wheel coefficient |travel| / dist,
// one quotient bit per stage, saturating. Also rounds the step targets.
// ----------------------------------------------------------------------------
module odk_div3
  import odk_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [DIST_W-1:0]           in_dist,
  input  side_t                       in_side,
  output logic                        out_valid,
  output logic [2:0][QW-1:0]          out_coef,
  output logic [2:0][TGT_W-1:0]       out_tgt,
  output logic [SPD_W-1:0]            out_spd,
  output logic                        out_zero
);

  typedef struct packed {
    logic [2:0][DEN_W-1:0]  rem;
    logic [2:0][QW-1:0]     nl;
    logic [2:0][QW-1:0]     q;
    logic [DEN_W-1:0]       den;
    logic [2:0]             ovf;
    logic                   zero;
    logic [2:0][TGT_W-1:0]  tgt;
    logic [SPD_W-1:0]       spd;
  } div_st_t;

  logic    vld_r [QW+1];
  div_st_t st_r  [QW+1];

  // prep stage
  div_st_t          prep;
  logic [DEN_W-1:0] den;

  assign den = DEN_W'(in_dist) << CB;

  always_comb begin
    logic signed [T_W-1:0] t, tn, sh;
    logic [MAG_W-1:0]      mag;
    logic [NUM_W-1:0]      num, numh;
    prep      = '0;
    prep.den  = den;
    prep.zero = (in_dist == '0);
    prep.spd  = in_side.spd;
    for (int l = 0; l < 3; l++) begin
      t    = $signed(in_side.t16[l]);
      tn   = -t;
      mag  = t[T_W-1] ? tn[MAG_W-1:0] : t[MAG_W-1:0];
      num  = NUM_W'(mag) << CA;
      numh = num >> QW;
      prep.ovf[l] = (numh >= NUM_W'(den));
      prep.rem[l] = numh[DEN_W-1:0];
      prep.nl[l]  = num[QW-1:0];
      // truncate toward zero
      sh = t[T_W-1] ? ((t + T_W'(65535)) >>> 16) : (t >>> 16);
      prep.tgt[l] = {{(TGT_W-(T_W-16)){sh[T_W-17]}}, sh[T_W-17:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= prep;
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    div_st_t st_nxt;

    always_comb begin
      logic [DEN_W:0] r2;
      logic           ge;
      st_nxt = st_r[s-1];
      for (int l = 0; l < 3; l++) begin
        r2 = {st_r[s-1].rem[l], st_r[s-1].nl[l][QW-1]};
        ge = (r2 >= {1'b0, st_r[s-1].den});
        st_nxt.rem[l] = ge ? DEN_W'(r2 - {1'b0, st_r[s-1].den}) : r2[DEN_W-1:0];
        st_nxt.q[l]   = {st_r[s-1].q[l][QW-2:0], ge};
        st_nxt.nl[l]  = {st_r[s-1].nl[l][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      st_r[s] <= st_nxt;
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_coef[l] = st_r[QW].ovf[l] ? {QW{1'b1}} : st_r[QW].q[l];
    end
  end

  assign out_valid = vld_r[QW];
  assign out_tgt   = st_r[QW].tgt;
  assign out_spd   = st_r[QW].spd;
  assign out_zero  = st_r[QW].zero;

  // zero distance must have taken the saturating path on every lane
  a_zero_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[QW] && st_r[QW].zero) |-> (&st_r[QW].ovf))
    else $error("zero distance without divider overflow");

  a_div_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QW] |-> $past(in_valid, QW+1))
    else $error("divider result without a request");

endmodule

@@ hw/rtl/odk_scale.sv @@
// ----------------------------------------------------------------------------
// odk_scale
// Scales cruise, start and acceleration by each wheel coefficient and
// saturates each scaled value; zero moves are forced to all zeros.
// ----------------------------------------------------------------------------
module odk_scale
  import odk_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [2:0][QW-1:0]          in_coef,
  input  logic [2:0][TGT_W-1:0]       in_tgt,
  input  logic [SPD_W-1:0]            in_spd,
  input  logic                        in_zero,
  input  logic [MINSPD_W-1:0]         min_speed,
  input  logic [ACC_W-1:0]            max_accel,
  output logic                        out_valid,
  output logic [2:0][TGT_W-1:0]       out_tgt,
  output logic [2:0][CRU_W-1:0]       out_cruise,
  output logic [2:0][STA_W-1:0]       out_start,
  output logic [2:0][ACCO_W-1:0]      out_accel
);

  logic                              va_r, vb_r;
  logic [2:0][SPD_W+QW-1:0]          pc_r;
  logic [2:0][MINSPD_W+QW-1:0]       pm_r;
  logic [2:0][ACC_W+QW-1:0]          pa_r;
  logic [2:0][TGT_W-1:0]             tgta_r, tgt_r;
  logic                              zeroa_r;
  logic [2:0][CRU_W-1:0]             cru_r;
  logic [2:0][STA_W-1:0]             sta_r;
  logic [2:0][ACCO_W-1:0]            acc_r;

  logic [2:0][TGT_W-1:0]             tgt_nxt;
  logic [2:0][CRU_W-1:0]             cru_nxt;
  logic [2:0][STA_W-1:0]             sta_nxt;
  logic [2:0][ACCO_W-1:0]            acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      pc_r[l] <= in_spd * in_coef[l];
      pm_r[l] <= min_speed * in_coef[l];
      pa_r[l] <= max_accel * in_coef[l];
    end
    tgta_r  <= in_tgt;
    zeroa_r <= in_zero;
  end

  always_comb begin
    logic [63:0] vc, vm, va;
    for (int l = 0; l < 3; l++) begin
      vc = sat_u(64'(pc_r[l] >> COEFF_FRAC_BITS), CRU_W);
      vm = sat_u(64'(pm_r[l] >> COEFF_FRAC_BITS), STA_W);
      va = sat_u(64'(pa_r[l] >> COEFF_FRAC_BITS), ACCO_W);
      tgt_nxt[l] = zeroa_r ? '0 : tgta_r[l];
      cru_nxt[l] = zeroa_r ? '0 : vc[CRU_W-1:0];
      sta_nxt[l] = zeroa_r ? '0 : vm[STA_W-1:0];
      acc_nxt[l] = zeroa_r ? '0 : va[ACCO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    cru_r <= cru_nxt;
    sta_r <= sta_nxt;
    acc_r <= acc_nxt;
  end

  assign out_valid  = vb_r;
  assign out_tgt    = tgt_r;
  assign out_cruise = cru_r;
  assign out_start  = sta_r;
  assign out_accel  = acc_r;

endmodule

@@ hw/rtl/omni_drive_cartesian_kinematics_top.sv @@
// ----------------------------------------------------------------------------
// omni_drive_cartesian_kinematics_top
// Three-wheel omni drive inverse kinematics for one planar move request.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high; busy is always low.
// Each request yields one result strobe out_valid after it has passed 3 front
// stages, 28 square-root stages, 19 divider stages with their prep stage and
// 2 scaling stages, in request order. The result is shown for that single
// cycle and must be captured then; there is no back-pressure.
// Configuration writes take effect at once and must only be made while no
// request is in flight.
module omni_drive_cartesian_kinematics_top
  import odk_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [DIN_W-1:0]    in_delta_x_mm,
  input  logic signed [DIN_W-1:0]    in_delta_y_mm,
  input  logic [SPDIN_W-1:0]         in_speed_mm,
  input  logic                       cfg_we,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  output logic                       out_valid,
  output logic signed [TGT_W-1:0]    out_target_front,
  output logic signed [TGT_W-1:0]    out_target_rear_left,
  output logic signed [TGT_W-1:0]    out_target_rear_right,
  output logic [CRU_W-1:0]           out_cruise_front,
  output logic [CRU_W-1:0]           out_cruise_rear_left,
  output logic [CRU_W-1:0]           out_cruise_rear_right,
  output logic [STA_W-1:0]           out_start_front,
  output logic [STA_W-1:0]           out_start_rear_left,
  output logic [STA_W-1:0]           out_start_rear_right,
  output logic [ACCO_W-1:0]          out_accel_front,
  output logic [ACCO_W-1:0]          out_accel_rear_left,
  output logic [ACCO_W-1:0]          out_accel_rear_right
);

  logic [STEPS_W-1:0]  steps_r;
  logic [MINSPD_W-1:0] min_speed_r;
  logic [ACC_W-1:0]    max_accel_r;

  logic                accept;
  logic                f_valid, s_valid, d_valid;
  logic [SQ_W-1:0]     f_sq;
  side_t               f_side, s_side;
  logic [DIST_W-1:0]   s_root;
  logic [2:0][QW-1:0]      d_coef;
  logic [2:0][TGT_W-1:0]   d_tgt, o_tgt;
  logic [SPD_W-1:0]        d_spd;
  logic                    d_zero;
  logic [2:0][CRU_W-1:0]   o_cru;
  logic [2:0][STA_W-1:0]   o_sta;
  logic [2:0][ACCO_W-1:0]  o_acc;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= STEPS_W'(1);
      min_speed_r <= '0;
      max_accel_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_STEPS_PER_MM: steps_r     <= cfg_wdata[STEPS_W-1:0];
        REG_MIN_SPEED:    min_speed_r <= cfg_wdata[MINSPD_W-1:0];
        REG_MAX_ACCEL:    max_accel_r <= cfg_wdata[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  odk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_dx     (in_delta_x_mm),
    .in_dy     (in_delta_y_mm),
    .in_spd    (in_speed_mm),
    .steps     (steps_r),
    .out_valid (f_valid),
    .out_sq    (f_sq),
    .out_side  (f_side)
  );

  odk_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_x      (f_sq),
    .in_side   (f_side),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  odk_div3 u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_dist   (s_root),
    .in_side   (s_side),
    .out_valid (d_valid),
    .out_coef  (d_coef),
    .out_tgt   (d_tgt),
    .out_spd   (d_spd),
    .out_zero  (d_zero)
  );

  odk_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d_valid),
    .in_coef    (d_coef),
    .in_tgt     (d_tgt),
    .in_spd     (d_spd),
    .in_zero    (d_zero),
    .min_speed  (min_speed_r),
    .max_accel  (max_accel_r),
    .out_valid  (out_valid),
    .out_tgt    (o_tgt),
    .out_cruise (o_cru),
    .out_start  (o_sta),
    .out_accel  (o_acc)
  );

  assign out_target_front      = o_tgt[0];
  assign out_target_rear_left  = o_tgt[1];
  assign out_target_rear_right = o_tgt[2];
  assign out_cruise_front      = o_cru[0];
  assign out_cruise_rear_left  = o_cru[1];
  assign out_cruise_rear_right = o_cru[2];
  assign out_start_front       = o_sta[0];
  assign out_start_rear_left   = o_sta[1];
  assign out_start_rear_right  = o_sta[2];
  assign out_accel_front       = o_acc[0];
  assign out_accel_rear_left   = o_acc[1];
  assign out_accel_rear_right  = o_acc[2];

  a_out_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching request");

endmodule

@@ bench/odk_checker.sv @@
// ----------------------------------------------------------------------------
// odk_checker
// Watches the request and result channels of the omni drive kinematics block,
// predicts each result from the request and the register values, and counts
// mismatches.
// ----------------------------------------------------------------------------
module odk_checker
  import odk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [DIN_W-1:0] in_delta_x_mm,
  input  logic signed [DIN_W-1:0] in_delta_y_mm,
  input  logic [SPDIN_W-1:0]      in_speed_mm,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    out_valid,
  input  logic [TGT_W-1:0]        out_target_front,
  input  logic [TGT_W-1:0]        out_target_rear_left,
  input  logic [TGT_W-1:0]        out_target_rear_right,
  input  logic [CRU_W-1:0]        out_cruise_front,
  input  logic [CRU_W-1:0]        out_cruise_rear_left,
  input  logic [CRU_W-1:0]        out_cruise_rear_right,
  input  logic [STA_W-1:0]        out_start_front,
  input  logic [STA_W-1:0]        out_start_rear_left,
  input  logic [STA_W-1:0]        out_start_rear_right,
  input  logic [ACCO_W-1:0]       out_accel_front,
  input  logic [ACCO_W-1:0]       out_accel_rear_left,
  input  logic [ACCO_W-1:0]       out_accel_rear_right,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [TGT_W-1:0]  tgt [3];
    logic [CRU_W-1:0]  cru [3];
    logic [STA_W-1:0]  sta [3];
    logic [ACCO_W-1:0] acc [3];
  } wheel_cmd_t;

  logic [STEPS_W-1:0]  steps_per_mm;
  logic [MINSPD_W-1:0] min_speed;
  logic [ACC_W-1:0]    max_accel;
  wheel_cmd_t          wheel_q [$];

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] clamp_u(input logic [63:0] v, input int w);
    logic [63:0] m;
    m = (64'd1 << w) - 1;
    return (v > m) ? m : v;
  endfunction

  function automatic wheel_cmd_t move_to_wheels(input logic signed [15:0] dxm,
                                                input logic signed [15:0] dym,
                                                input logic [12:0] spm);
    wheel_cmd_t r;
    longint dx, dy, q, t [3];
    logic [63:0] ax, ay, path_len, spd, mag, c, cmax;
    dx = longint'(dxm) * longint'(steps_per_mm);
    dy = longint'(dym) * longint'(steps_per_mm);
    spd = 64'(spm) * 64'(steps_per_mm);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    path_len = root_floor(ax * ax + ay * ay);
    cmax = (64'd1 << (COEFF_FRAC_BITS + 2)) - 1;
    t[0] = -dx * 65536;
    t[1] = dx * 32768 - 64'sd56754 * dy;
    t[2] = dx * 32768 + 64'sd56754 * dy;
    for (int i = 0; i < 3; i++) begin
      if (path_len == 0) begin
        r.tgt[i] = 0; r.cru[i] = 0; r.sta[i] = 0; r.acc[i] = 0;
      end else begin
        q = t[i] >= 0 ? t[i] / 65536 : -((-t[i]) / 65536);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        r.tgt[i] = q[31:0];
        mag = t[i] < 0 ? -t[i] : t[i];
        if (COEFF_FRAC_BITS >= 16) c = (mag << (COEFF_FRAC_BITS - 16)) / path_len;
        else c = mag / (path_len << (16 - COEFF_FRAC_BITS));
        if (c > cmax) c = cmax;
        r.cru[i] = CRU_W'(clamp_u((spd * c) >> COEFF_FRAC_BITS, CRU_W));
        r.sta[i] = STA_W'(clamp_u((64'(min_speed) * c) >> COEFF_FRAC_BITS, STA_W));
        r.acc[i] = ACCO_W'(clamp_u((64'(max_accel) * c) >> COEFF_FRAC_BITS, ACCO_W));
      end
    end
    return r;
  endfunction

  task automatic cmp(input string name, input logic [31:0] exp_v,
                     input logic [31:0] got);
    if (exp_v !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, got);
      fail_count++;
    end
  endtask

  assign pending = wheel_q.size();

  always_ff @(posedge clk) begin
    wheel_cmd_t e;
    logic [31:0] gt [3], gc [3], gs [3], ga [3];
    if (!rst_n) begin
      steps_per_mm <= 1;
      min_speed    <= 0;
      max_accel    <= 0;
      fail_count   = 0;
      wheel_q.delete();
    end else begin
      if (out_valid) begin
        if (wheel_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0h", $time,
                   out_target_front);
          fail_count++;
        end else begin
          e = wheel_q.pop_front();
          gt = '{out_target_front, out_target_rear_left, out_target_rear_right};
          gc = '{out_cruise_front, out_cruise_rear_left, out_cruise_rear_right};
          gs = '{out_start_front, out_start_rear_left, out_start_rear_right};
          ga = '{out_accel_front, out_accel_rear_left, out_accel_rear_right};
          for (int i = 0; i < 3; i++) begin
            cmp($sformatf("target[%0d]", i), e.tgt[i], gt[i]);
            cmp($sformatf("cruise[%0d]", i), e.cru[i], gc[i]);
            cmp($sformatf("start[%0d]", i), e.sta[i], gs[i]);
            cmp($sformatf("accel[%0d]", i), e.acc[i], ga[i]);
          end
        end
      end
      if (start && !busy)
        wheel_q.push_back(move_to_wheels(in_delta_x_mm, in_delta_y_mm, in_speed_mm));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_STEPS_PER_MM: steps_per_mm <= cfg_wdata[STEPS_W-1:0];
          REG_MIN_SPEED:    min_speed    <= cfg_wdata[MINSPD_W-1:0];
          REG_MAX_ACCEL:    max_accel    <= cfg_wdata[ACC_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives move requests and register writes into the omni drive kinematics
// block through several register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import odk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0, start = 0, busy, cfg_we = 0, out_valid;
  logic signed [DIN_W-1:0] in_delta_x_mm = 0, in_delta_y_mm = 0;
  logic [SPDIN_W-1:0] in_speed_mm = 0;
  logic [IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_wdata = 0;
  logic [TGT_W-1:0] tf, tl, tr;
  logic [CRU_W-1:0] cf, cl, cr;
  logic [STA_W-1:0] sf, sl, sr;
  logic [ACCO_W-1:0] af, al, ar;
  int fail_count, pending, cycles = 0, idle_pct = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  omni_drive_cartesian_kinematics_top dut (
    .clk, .rst_n, .start, .busy, .in_delta_x_mm, .in_delta_y_mm, .in_speed_mm,
    .cfg_we, .cfg_index, .cfg_wdata, .out_valid,
    .out_target_front(tf), .out_target_rear_left(tl), .out_target_rear_right(tr),
    .out_cruise_front(cf), .out_cruise_rear_left(cl), .out_cruise_rear_right(cr),
    .out_start_front(sf), .out_start_rear_left(sl), .out_start_rear_right(sr),
    .out_accel_front(af), .out_accel_rear_left(al), .out_accel_rear_right(ar));

  odk_checker chk (
    .clk, .rst_n, .start, .busy, .in_delta_x_mm, .in_delta_y_mm, .in_speed_mm,
    .cfg_we, .cfg_index, .cfg_wdata, .out_valid,
    .out_target_front(tf), .out_target_rear_left(tl), .out_target_rear_right(tr),
    .out_cruise_front(cf), .out_cruise_rear_left(cl), .out_cruise_rear_right(cr),
    .out_start_front(sf), .out_start_rear_left(sl), .out_start_rear_right(sr),
    .out_accel_front(af), .out_accel_rear_left(al), .out_accel_rear_right(ar),
    .fail_count, .pending);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_move(input logic [15:0] dx, input logic [15:0] dy,
                           input logic [12:0] spd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_delta_x_mm <= dx;
    in_delta_y_mm <= dy;
    in_speed_mm <= spd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // idle point: nothing outstanding, then let the pipeline drain
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_moves(input int n);
    logic [15:0] dx, dy;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin dx = $urandom; dy = $urandom; end
        1: begin dx = $urandom_range(200) - 100; dy = $urandom_range(200) - 100; end
        2: begin dx = $urandom_range(1) ? 16'h8000 : 16'h7fff; dy = $urandom; end
        default: begin dx = $urandom_range(3) == 0 ? 0 : $urandom;
                       dy = dx == 0 ? $urandom : ($urandom_range(2) == 0 ? 0 : $urandom);
        end
      endcase
      send_move(dx, dy, $urandom_range(3) == 0 ? 13'h1fff : $urandom);
    end
  endtask

  initial begin
    logic [15:0] xs [6];
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    xs = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0064};
    // defaults first, then extremes
    send_move(0, 0, 13'h1fff);
    send_move(100, 0, 100);
    drain();
    write_reg(REG_STEPS_PER_MM, 4095);
    write_reg(REG_MIN_SPEED, 18'h3ffff);
    write_reg(REG_MAX_ACCEL, 16'hffff);
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 3; j++)
        send_move(xs[i], xs[j + 2 * (i % 2)], i[0] ? 13'h1fff : 0);
    send_move(0, 0, 13'h1fff);
    drain();
    write_reg(REG_STEPS_PER_MM, 0);
    send_move(16'h7fff, 16'h8000, 13'h1fff);
    send_move(5, 5, 13'h1fff);
    drain();
    write_reg(REG_STEPS_PER_MM, 1);
    write_reg(REG_MIN_SPEED, 0);
    write_reg(REG_MAX_ACCEL, 0);
    idle_pct = 12;
    random_moves(400);
    drain();
    write_reg(REG_STEPS_PER_MM, 4095);
    write_reg(REG_MIN_SPEED, 18'h3ffff);
    write_reg(REG_MAX_ACCEL, 16'hffff);
    idle_pct = 67;
    random_moves(400);
    drain();
    idle_pct = 0;
    for (int k = 0; k < 3; k++) begin
      write_reg(REG_STEPS_PER_MM, $urandom_range(4095, 1));
      write_reg(REG_MIN_SPEED, $urandom);
      write_reg(REG_MAX_ACCEL, $urandom);
      random_moves(300);
      drain();
    end
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/odk_pkg.sv
hw/rtl/odk_front.sv
hw/rtl/odk_isqrt.sv
hw/rtl/odk_div3.sv
hw/rtl/odk_scale.sv
hw/rtl/omni_drive_cartesian_kinematics_top.sv
bench/odk_checker.sv
bench/tb.sv
